### rtl/md5sh_pkg.sv
// Shared types, constants and index helpers for the MD5 stream hasher.
package md5sh_pkg;

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts, indexed by {round group, round[1:0]}
    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic       start;
        logic       init;
        logic       wr_en;
        logic [3:0] wr_addr;
    } t_core_cmd;

    // message word used by a given round
    function automatic logic [3:0] word_idx(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] res;
        lo = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: res = lo;
            2'd1: res = lo * 4'd5 + 4'd1;
            2'd2: res = lo * 4'd3 + 4'd5;
            default: res = lo * 4'd7;
        endcase
        return res;
    endfunction

endpackage

### rtl/md5sh_core.sv
// MD5 compression engine: word store, one round unit run 64 times, chaining words.
module md5sh_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  md5sh_pkg::t_core_cmd  i_cmd,
    input  logic [31:0]           i_wr_data,
    output logic                  o_busy,
    output logic [3:0][31:0]      o_chain
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_FETCH = 2'd1;
    localparam logic [1:0] C_ROUND = 2'd2;
    localparam logic [1:0] C_ADD   = 2'd3;

    logic [1:0]       r_state;
    logic [5:0]       r_round;
    logic [3:0][31:0] r_h;
    logic [31:0]      r_a, r_b, r_c, r_d;
    logic [31:0]      r_mem [16];
    logic [31:0]      r_wdat;

    logic [3:0]       rd_addr;
    logic [31:0]      fn;
    logic [31:0]      sum;
    logic [63:0]      rot2;
    logic [4:0]       shamt;
    logic [31:0]      n_b;

    // read one round ahead so the word is registered when its round runs
    assign rd_addr = md5sh_pkg::word_idx((r_state == C_FETCH) ? 6'd0 : r_round + 6'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_wr_data;
        end
        r_wdat <= r_mem[rd_addr];
    end

    always_comb begin
        unique case (r_round[5:4])
            2'd0: fn = (r_b & r_c) | (~r_b & r_d);
            2'd1: fn = (r_d & r_b) | (~r_d & r_c);
            2'd2: fn = r_b ^ r_c ^ r_d;
            default: fn = r_c ^ (r_b | ~r_d);
        endcase
        sum   = r_a + fn + md5sh_pkg::MD5_K[r_round] + r_wdat;
        shamt = md5sh_pkg::MD5_S[{r_round[5:4], r_round[1:0]}];
        rot2  = {sum, sum} << shamt;
        n_b   = r_b + rot2[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            for (int i = 0; i < 4; i++) begin
                r_h[i] <= md5sh_pkg::MD5_IV[i];
            end
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_cmd.init) begin
                        for (int i = 0; i < 4; i++) begin
                            r_h[i] <= md5sh_pkg::MD5_IV[i];
                        end
                    end
                    if (i_cmd.start) begin
                        r_state <= C_FETCH;
                        r_round <= '0;
                    end
                end
                C_FETCH: begin
                    r_state <= C_ROUND;
                end
                C_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= C_ADD;
                    end
                end
                default: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_cmd.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (r_state == C_ROUND) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= n_b;
        end
    end

    assign o_busy  = (r_state != C_IDLE);
    assign o_chain = r_h;

endmodule

### rtl/md5_stream_hasher_top.sv
// MD5 stream hasher top level: byte intake, padding sequencer and digest output.
//
// Takes a message one byte per transfer and returns the 128-bit MD5 digest as four
// 32-bit word transfers, word 0 first, each word's low byte being the earliest digest
// byte. A byte transfer that does not complete a 64-byte block is taken without a
// stall. The transfer that completes a block holds the input off while the single
// round unit does one word fetch, runs the 64 rounds one per cycle, does the
// chaining add and hands back to the sequencer. An end-of-message transfer then
// feeds the padding and length bytes one per cycle, pausing while a compression
// runs, through the same byte path (9 to 72 bytes), runs one or two more
// compressions, and hands out the four digest words, subject to output
// back-pressure. After the digest the hasher is back at the initial vector, ready
// for the next message.
module md5_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [33:32] word_index, rest 0
    output logic        m_axis_tlast    // last_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COMP = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] P_MARK = 2'd0;
    localparam logic [1:0] P_ZERO = 2'd1;
    localparam logic [1:0] P_LEN  = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  r_ret;
    logic [5:0]  r_pos;
    logic [23:0] r_wbuf;
    logic [63:0] r_bits;
    logic [1:0]  r_pstep;
    logic [2:0]  r_lcnt;
    logic [1:0]  r_oidx;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [1:0]  r_oindex;
    logic        r_olast;

    logic                 accept;
    logic                 put_en;
    logic [7:0]           put_byte;
    logic                 out_load;
    logic [1:0]           n_state;
    logic                 core_busy;
    logic [3:0][31:0]     chain;
    md5sh_pkg::t_core_cmd core_cmd;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        put_en   = 1'b0;
        put_byte = s_axis_tdata;
        if (r_state == ST_IDLE) begin
            put_en = accept && s_axis_tuser;
        end else if (r_state == ST_PAD) begin
            put_en = 1'b1;
            priority if (r_pstep == P_MARK) begin
                put_byte = md5sh_pkg::PAD_MARK;
            end else if (r_pstep == P_LEN) begin
                put_byte = r_bits[{r_lcnt, 3'b000} +: 8];
            end else begin
                put_byte = 8'h00;
            end
        end
    end

    always_comb begin
        core_cmd.wr_en   = put_en && (r_pos[1:0] == 2'd3);
        core_cmd.wr_addr = r_pos[5:2];
        core_cmd.start   = put_en && (r_pos == 6'd63);
        core_cmd.init    = out_load && (r_oidx == 2'd3);
    end

    // where the sequencer goes once the current byte (if any) is taken
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = (accept && s_axis_tlast) ? ST_PAD : ST_IDLE;
            ST_PAD:  n_state = (r_pstep == P_LEN && r_lcnt == 3'd7) ? ST_OUT : ST_PAD;
            ST_COMP: n_state = r_ret;
            default: n_state = (out_load && r_oidx == 2'd3) ? ST_IDLE : ST_OUT;
        endcase
    end

    md5sh_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (core_cmd),
        .i_wr_data ({put_byte, r_wbuf}),
        .o_busy    (core_busy),
        .o_chain   (chain)
    );

    always_ff @(posedge i_clk) begin
        if (put_en) begin
            unique case (r_pos[1:0])
                2'd0: r_wbuf[7:0]   <= put_byte;
                2'd1: r_wbuf[15:8]  <= put_byte;
                2'd2: r_wbuf[23:16] <= put_byte;
                default: ;
            endcase
        end
        if (out_load) begin
            r_odata  <= chain[r_oidx];
            r_oindex <= r_oidx;
            r_olast  <= (r_oidx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_pos    <= '0;
            r_bits   <= '0;
            r_pstep  <= P_MARK;
            r_lcnt   <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (put_en) begin
                r_pos <= r_pos + 6'd1;
            end

            if (core_cmd.start) begin
                r_state <= ST_COMP;
                r_ret   <= n_state;
            end else if (r_state != ST_COMP || !core_busy) begin
                r_state <= n_state;
            end

            if (accept) begin
                r_pstep <= P_MARK;
                r_lcnt  <= '0;
                r_oidx  <= '0;
                if (s_axis_tuser) begin
                    r_bits <= r_bits + 64'd8;
                end
            end

            if (r_state == ST_PAD) begin
                if (r_pstep == P_LEN) begin
                    r_lcnt <= r_lcnt + 3'd1;
                end else begin
                    r_pstep <= (r_pos == 6'd55) ? P_LEN : P_ZERO;
                end
            end

            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_oidx   <= r_oidx + 2'd1;
            end
            if (core_cmd.init) begin
                r_bits <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b000000, r_oindex, r_odata};
    assign m_axis_tlast  = r_olast;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_cmd.start |-> !core_busy)
        else $error("compression started while engine busy");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !core_busy)
        else $error("byte taken during compression");

    a_len_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_pstep == P_LEN) |->
            (r_pos[5:3] == 3'b111 && r_pos[2:0] == r_lcnt))
        else $error("length bytes out of place in block");

    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_cmd.init |=> (r_state == ST_IDLE && r_pos == 6'd0 && r_bits == 64'd0))
        else $error("hasher not back at start after digest");

endmodule
